// ----- hdl/gbnwc_pkg.sv -----
// Shared constants and types for the go-back-N CRC acknowledgment checker.
`default_nettype none

package gbnwc_pkg;

   localparam int CODEWORD_BITS = 40;
   localparam int ID_BITS       = 2;
   localparam int POLY_BITS     = 8;
   localparam int STEP_BITS     = 8;
   localparam int REQ_DATA_BITS = 48;
   localparam int RSP_DATA_BITS = 8;

   localparam logic [POLY_BITS-1:0] POLY_RESET = 8'h07;

   typedef struct packed {
      logic [POLY_BITS-1:0] poly;
      logic [ID_BITS-1:0]   frame_id;
   } tag_type;

endpackage

`default_nettype wire

// ----- hdl/gbnwc_crc_stage.sv -----
// One pipeline stage of the CRC remainder: folds eight codeword bits into the remainder.
`default_nettype none

module gbnwc_crc_stage #(
   parameter int REM_BITS = 8,
   parameter int PAD_BITS = 40,
   parameter int STAGE    = 0
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      in_valid,
   output logic                     in_ready,
   input  wire [REM_BITS-1:0]       in_rem,
   input  wire [PAD_BITS-1:0]       in_word,
   input  gbnwc_pkg::tag_type       in_tag,
   output logic                     out_valid,
   input  wire                      out_ready,
   output logic [REM_BITS-1:0]      out_rem,
   output logic [PAD_BITS-1:0]      out_word,
   output gbnwc_pkg::tag_type       out_tag
);

   localparam int EXT_BITS = (REM_BITS > gbnwc_pkg::POLY_BITS) ? REM_BITS : gbnwc_pkg::POLY_BITS;
   localparam int TOP_BIT  = PAD_BITS - 1 - gbnwc_pkg::STEP_BITS * STAGE;

   logic                 valid_ff;
   logic [REM_BITS-1:0]  rem_ff;
   logic [REM_BITS-1:0]  rem_in;
   logic [PAD_BITS-1:0]  word_ff;
   gbnwc_pkg::tag_type   tag_ff;
   logic [EXT_BITS-1:0]  poly_ext;
   logic [REM_BITS-1:0]  low_terms;
   logic [REM_BITS:0]    shifted;

   assign poly_ext  = EXT_BITS'(in_tag.poly);
   assign low_terms = poly_ext[REM_BITS-1:0];

   always_comb begin
      rem_in  = in_rem;
      shifted = '0;
      for (int k = 0; k < gbnwc_pkg::STEP_BITS; k++) begin
         shifted = {rem_in, in_word[TOP_BIT-k]};
         if (shifted[REM_BITS]) begin
            rem_in = shifted[REM_BITS-1:0] ^ low_terms;
         end else begin
            rem_in = shifted[REM_BITS-1:0];
         end
      end
   end

   assign in_ready = !valid_ff || out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (in_valid && in_ready) begin
         valid_ff <= 1'b1;
      end else if (out_ready) begin
         valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         rem_ff  <= rem_in;
         word_ff <= in_word;
         tag_ff  <= in_tag;
      end
   end

   assign out_valid = valid_ff;
   assign out_rem   = rem_ff;
   assign out_word  = word_ff;
   assign out_tag   = tag_ff;

endmodule

`default_nettype wire

// ----- hdl/gbn_window_crc_ack_checker_core.sv -----
// Top level of the go-back-N receiver checker with a configurable CRC-8 frame check.
//
// Each input item carries one codeword and its frame id. The codeword's remainder
// modulo the CRC divisor (x^8 plus the low terms held in the poly register) must be
// zero for the frame to be good. Frames are grouped in windows of WINDOW_FRAMES; the
// last frame of a window yields one output item: an ACK with the next expected id when
// every frame was good, or a NACK with the id of the first bad frame.
// The remainder is computed by a pipeline of ceil(min(FRAME_BITS, 40) / 8) stages,
// each folding eight bits, followed by the window logic and an output register.
// One item is accepted every cycle unless a waiting reply stalls the pipeline.
// The poly register is written through csr_wr_en and csr_wr_data; each item keeps
// the poly value that was current when it was accepted.
// Reset clears the window state, empties the pipeline and sets the poly to 0x07.
// When the receiver stalls, a waiting reply holds in the output register while the
// pipeline keeps taking items until its stages fill up.
`default_nettype none

module gbn_window_crc_ack_checker_core #(
   parameter int FRAME_BITS    = 40,
   parameter int DIVISOR_BITS  = 9,
   parameter int WINDOW_FRAMES = 3
) (
   input  wire                                   clock,
   input  wire                                   reset,
   input  wire                                   csr_wr_en,
   input  wire [gbnwc_pkg::POLY_BITS-1:0]        csr_wr_data,
   input  wire                                   req_tvalid,
   output logic                                  req_tready,
   // Fields from bit 0: codeword[39:0], frame_id[41:40], zero fill.
   input  wire [gbnwc_pkg::REQ_DATA_BITS-1:0]    req_tdata,
   output logic                                  rsp_tvalid,
   input  wire                                   rsp_tready,
   // Fields from bit 0: reply_id[1:0], zero fill.
   output logic [gbnwc_pkg::RSP_DATA_BITS-1:0]   rsp_tdata,
   // Fields from bit 0: reply_ack[0].
   output logic                                  rsp_tuser
);

   localparam int CHECK_BITS = (FRAME_BITS < gbnwc_pkg::CODEWORD_BITS) ?
                               FRAME_BITS : gbnwc_pkg::CODEWORD_BITS;
   localparam int STAGES     = (CHECK_BITS + gbnwc_pkg::STEP_BITS - 1) / gbnwc_pkg::STEP_BITS;
   localparam int PAD_BITS   = STAGES * gbnwc_pkg::STEP_BITS;
   localparam int REM_BITS   = DIVISOR_BITS - 1;
   localparam int POS_BITS   = (WINDOW_FRAMES > 1) ? $clog2(WINDOW_FRAMES) : 1;
   localparam logic [POS_BITS-1:0] LAST_POS = POS_BITS'(WINDOW_FRAMES - 1);

   logic [gbnwc_pkg::POLY_BITS-1:0] poly_ff;

   logic                  valid_chain [STAGES+1];
   logic                  ready_chain [STAGES+1];
   logic [REM_BITS-1:0]   rem_chain   [STAGES+1];
   logic [PAD_BITS-1:0]   word_chain  [STAGES+1];
   gbnwc_pkg::tag_type    tag_chain   [STAGES+1];

   logic [POS_BITS-1:0]             window_pos_ff;
   logic                            error_seen_ff;
   logic [gbnwc_pkg::ID_BITS-1:0]   first_bad_ff;

   logic                            rsp_valid_ff;
   logic                            rsp_ack_ff;
   logic [gbnwc_pkg::ID_BITS-1:0]   rsp_id_ff;

   logic                            last_valid;
   logic                            is_last;
   logic                            frame_bad;
   logic                            err_now;
   logic [gbnwc_pkg::ID_BITS-1:0]   bad_id;
   logic                            rsp_free;
   logic                            take;
   logic                            load;
   logic                            reply_ack_in;
   logic [gbnwc_pkg::ID_BITS-1:0]   reply_id_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         poly_ff <= gbnwc_pkg::POLY_RESET;
      end else if (csr_wr_en) begin
         poly_ff <= csr_wr_data;
      end
   end

   assign valid_chain[0]          = req_tvalid;
   assign req_tready              = ready_chain[0];
   assign rem_chain[0]            = '0;
   assign word_chain[0]           = PAD_BITS'(req_tdata[CHECK_BITS-1:0]);
   assign tag_chain[0].poly       = poly_ff;
   assign tag_chain[0].frame_id   =
      req_tdata[gbnwc_pkg::CODEWORD_BITS+gbnwc_pkg::ID_BITS-1:gbnwc_pkg::CODEWORD_BITS];

   for (genvar s = 0; s < STAGES; s++) begin : g_stage
      gbnwc_crc_stage #(
         .REM_BITS (REM_BITS),
         .PAD_BITS (PAD_BITS),
         .STAGE    (s)
      ) u_stage (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (valid_chain[s]),
         .in_ready  (ready_chain[s]),
         .in_rem    (rem_chain[s]),
         .in_word   (word_chain[s]),
         .in_tag    (tag_chain[s]),
         .out_valid (valid_chain[s+1]),
         .out_ready (ready_chain[s+1]),
         .out_rem   (rem_chain[s+1]),
         .out_word  (word_chain[s+1]),
         .out_tag   (tag_chain[s+1])
      );
   end

   assign last_valid = valid_chain[STAGES];
   assign is_last    = (window_pos_ff == LAST_POS);
   assign frame_bad  = (rem_chain[STAGES] != '0);
   assign err_now    = error_seen_ff || frame_bad;
   assign bad_id     = error_seen_ff ? first_bad_ff : tag_chain[STAGES].frame_id;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   assign ready_chain[STAGES] = !is_last || rsp_free;
   assign take                = last_valid && ready_chain[STAGES];
   assign load                = take && is_last;

   assign reply_ack_in = !err_now;
   assign reply_id_in  = err_now ? bad_id :
                         tag_chain[STAGES].frame_id + gbnwc_pkg::ID_BITS'(1);

   always_ff @(posedge clock) begin
      if (reset) begin
         window_pos_ff <= '0;
         error_seen_ff <= 1'b0;
         first_bad_ff  <= '0;
      end else if (take) begin
         if (is_last) begin
            window_pos_ff <= '0;
            error_seen_ff <= 1'b0;
            first_bad_ff  <= '0;
         end else begin
            window_pos_ff <= window_pos_ff + POS_BITS'(1);
            error_seen_ff <= err_now;
            first_bad_ff  <= bad_id;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ack_ff <= reply_ack_in;
         rsp_id_ff  <= reply_id_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ack_ff;
   assign rsp_tdata  = gbnwc_pkg::RSP_DATA_BITS'(rsp_id_ff);

   a_pos_range : assert property (@(posedge clock) disable iff (reset)
      window_pos_ff <= LAST_POS)
      else $error("window position beyond the window");

   a_pos_step : assert property (@(posedge clock) disable iff (reset)
      (take && !is_last) |=> (window_pos_ff == $past(window_pos_ff) + POS_BITS'(1)))
      else $error("window position did not advance");

   a_window_clear : assert property (@(posedge clock) disable iff (reset)
      load |=> (rsp_valid_ff && window_pos_ff == '0 && !error_seen_ff))
      else $error("window state not cleared after a reply");

   a_no_overwrite : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !load)
      else $error("pending reply overwritten");

endmodule

`default_nettype wire
